[rtl/core/clsp_pkg.sv]
// Shared constants, types and the modular reduction for the combined LCG generator.
// Used by the controller, datapath, slot divider and top level; no dependencies.
package clsp_pkg;

  localparam int TABLE_SIZE_DEF = 32;

  localparam logic [30:0] MOD_ONE       = 31'd2147483563;
  localparam logic [30:0] MOD_TWO       = 31'd2147483399;
  localparam logic [30:0] MOD_ONE_LESS  = 31'd2147483562;
  localparam logic [15:0] MUL_ONE       = 16'd40014;
  localparam logic [15:0] MUL_TWO       = 16'd40692;
  // 2^31 minus each modulus: folds the product's upper bits back in
  localparam logic [7:0]  FOLD_ONE      = 8'd85;
  localparam logic [7:0]  FOLD_TWO      = 8'd249;
  localparam logic [30:0] GEN_TWO_RESET = 31'd123456789;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef struct packed {
    logic mul_load;     // register both products
    logic div_start;    // start the slot divider on last_output
    logic gen_update;   // reduce both products into the generators
    logic tbl_read;     // read the picked slot
    logic draw_finish;  // write slot, update last_output, load result
    logic seed_load;    // load generators and step count from the seed
    logic seed_update;  // reduce generator one, fill table on the last steps
  } clsp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic step_last;
  } clsp_status_t;

  // (prod mod modulus) for modulus = 2^31 - fold and prod below 2^47
  function automatic logic [30:0] lcg_reduce(input logic [46:0] prod,
                                             input logic [7:0]  fold,
                                             input logic [30:0] modulus);
    logic [31:0] sum;
    sum = {1'b0, prod[30:0]} + 32'(prod[46:31]) * 32'(fold);
    if (sum >= {1'b0, modulus}) begin
      sum = sum - {1'b0, modulus};
    end
    return sum[30:0];
  endfunction

endpackage

[rtl/core/clsp_ctrl.sv]
// Controller state machine for the combined LCG generator.
// Depends on clsp_pkg for the command and status structs and command codes.
module clsp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tuser,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  clsp_pkg::clsp_status_t status,
  output clsp_pkg::clsp_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DRAW_RED = 3'd1;
  localparam logic [2:0] ST_DRAW_DIV = 3'd2;
  localparam logic [2:0] ST_DRAW_OUT = 3'd3;
  localparam logic [2:0] ST_SEED_MUL = 3'd4;
  localparam logic [2:0] ST_SEED_RED = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;
  logic       accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == clsp_pkg::CMD_RESEED) begin
            cmd.seed_load = 1'b1;
            state_next    = ST_SEED_MUL;
          end else begin
            cmd.mul_load  = 1'b1;
            cmd.div_start = 1'b1;
            state_next    = ST_DRAW_RED;
          end
        end
      end
      ST_DRAW_RED: begin
        cmd.gen_update = 1'b1;
        state_next     = ST_DRAW_DIV;
      end
      ST_DRAW_DIV: begin
        if (status.div_done) begin
          cmd.tbl_read = 1'b1;
          state_next   = ST_DRAW_OUT;
        end
      end
      ST_DRAW_OUT: begin
        // hold until the result register can take the item
        if (out_free) begin
          cmd.draw_finish = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_SEED_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_SEED_RED;
      end
      ST_SEED_RED: begin
        cmd.seed_update = 1'b1;
        state_next      = status.step_last ? ST_IDLE : ST_SEED_MUL;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.draw_finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/clsp_slot_div.sv]
// Slot picker: a reciprocal multiply estimates the quotient of the previous output by the
// slot width, and one compare and subtract in the next cycle corrects it. Uses clsp_pkg.
module clsp_slot_div #(
  parameter int TABLE_SIZE = clsp_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [30:0]                   dividend,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] slot
);

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int QW  = AW + 1;
  localparam int RSH = 37;
  localparam logic [32:0] SLOT_DIV = 33'(1 + clsp_pkg::MOD_ONE_LESS / TABLE_SIZE);
  // floor(2^RSH / SLOT_DIV): the estimate falls short of the quotient by at most one
  localparam logic [15:0] RECIP    = 16'((64'd1 << RSH) / 64'(SLOT_DIV));

  logic [46:0]   est_prod;
  logic [30:0]   num;
  logic [QW-1:0] est;
  logic [32:0]   rem;
  logic          ge;
  logic [QW-1:0] quo;
  logic          busy;

  assign est_prod = 47'(dividend) * 47'(RECIP);
  assign rem      = {2'b00, num} - 33'(est) * SLOT_DIV;
  assign ge       = (rem >= SLOT_DIV);
  assign done     = !busy;
  // quotient past the table is clamped to the last slot
  assign slot = (quo >= QW'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1) : quo[AW-1:0];

  // busy covers only the correction cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      est <= est_prod[RSH+QW-1:RSH];
    end
    if (busy) begin
      quo <= est + QW'(ge);
    end
  end

endmodule

[rtl/core/clsp_dpath.sv]
// Datapath: both generators, product registers, shuffle table and result register.
// Depends on clsp_pkg and instantiates clsp_slot_div.
module clsp_dpath #(
  parameter int TABLE_SIZE = clsp_pkg::TABLE_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  clsp_pkg::clsp_cmd_t   cmd,
  output clsp_pkg::clsp_status_t status,
  input  logic [30:0]           seed,
  output logic [30:0]           deviate
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 8);

  logic [30:0]           gen_one;
  logic [30:0]           gen_two;
  logic [30:0]           last_output;
  logic [46:0]           prod_one;
  logic [46:0]           prod_two;
  logic [CW-1:0]         step_cnt;
  logic [30:0]           red_one;
  logic [30:0]           red_two;
  logic [30:0]           seed_val;
  logic [AW-1:0]         slot;
  logic                  div_done;
  logic [30:0]           tbl_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] tbl_valid;
  logic [30:0]           rd_data;
  logic                  rd_valid;
  logic [30:0]           picked;
  logic [30:0]           out_val;
  logic                  seed_wr;
  logic                  tbl_wr;
  logic [AW-1:0]         wr_addr;
  logic [30:0]           wr_data;

  clsp_slot_div #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_slot_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (last_output),
    .done     (div_done),
    .slot     (slot)
  );

  assign red_one  = clsp_pkg::lcg_reduce(prod_one, clsp_pkg::FOLD_ONE, clsp_pkg::MOD_ONE);
  assign red_two  = clsp_pkg::lcg_reduce(prod_two, clsp_pkg::FOLD_TWO, clsp_pkg::MOD_TWO);
  assign seed_val = (seed == '0) ? 31'd1 : seed;

  assign status.div_done  = div_done;
  assign status.step_last = (step_cnt == '0);

  // a never-written slot reads as zero
  assign picked  = rd_valid ? rd_data : '0;
  assign out_val = (picked > gen_two) ? (picked - gen_two)
                                      : (clsp_pkg::MOD_ONE_LESS - (gen_two - picked));

  // the last TABLE_SIZE reseed steps fill the table from the top slot down
  assign seed_wr = cmd.seed_update && (step_cnt < CW'(TABLE_SIZE));
  assign tbl_wr  = seed_wr || cmd.draw_finish;
  assign wr_addr = cmd.draw_finish ? slot : step_cnt[AW-1:0];
  assign wr_data = cmd.draw_finish ? gen_one : red_one;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_one <= 47'(gen_one) * 47'(clsp_pkg::MUL_ONE);
      prod_two <= 47'(gen_two) * 47'(clsp_pkg::MUL_TWO);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_one     <= '0;
      gen_two     <= clsp_pkg::GEN_TWO_RESET;
      last_output <= '0;
      step_cnt    <= '0;
      tbl_valid   <= '0;
    end else begin
      if (cmd.seed_load) begin
        gen_one  <= seed_val;
        gen_two  <= seed_val;
        step_cnt <= CW'(TABLE_SIZE + 7);
      end
      if (cmd.gen_update) begin
        gen_one <= red_one;
        gen_two <= red_two;
      end
      if (cmd.seed_update) begin
        gen_one <= red_one;
        if (step_cnt == '0) begin
          last_output <= red_one;
        end else begin
          step_cnt <= step_cnt - 1'b1;
        end
      end
      if (cmd.draw_finish) begin
        last_output <= out_val;
      end
      if (tbl_wr) begin
        tbl_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (cmd.tbl_read) begin
      rd_data  <= tbl_mem[slot];
      rd_valid <= tbl_valid[slot];
    end
    if (cmd.draw_finish) begin
      deviate <= out_val;
    end
  end

endmodule

[rtl/core/combined_lcg_shuffled_prng_top.sv]
// Combined LCG generator with shuffle table. A draw runs through multiply (slot estimate
// alongside), reduce (slot correction alongside) and table read states; it finishes once
// the result register is free, and a new item is taken the cycle after; no new item is
// taken before the last one finishes. A reseed loads the seed, then runs a multiply and a
// reduce state for each generator step. Synchronous reset: generator one, the last
// output and every table slot read as 0, generator two as 123456789.
module combined_lcg_shuffled_prng_top #(
  parameter int TABLE_SIZE = clsp_pkg::TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] seed, [31] zero
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [30:0] deviate, [31] zero
);

  clsp_pkg::clsp_cmd_t    cmd;
  clsp_pkg::clsp_status_t status;
  logic [30:0]            deviate;

  clsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  clsp_dpath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .seed    (s_tdata[30:0]),
    .deviate (deviate)
  );

  assign m_tdata = {1'b0, deviate};

endmodule

[tb/tb_combined_lcg_shuffled_prng_top.sv]
// Self-checking bench for combined_lcg_shuffled_prng_top: streams draw and reseed items,
// predicts each deviate with a local copy of both generators and the shuffle table.
// Depends on clsp_pkg for the command codes only.
module tb_combined_lcg_shuffled_prng_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SHUF_N = 32;
  localparam longint M1     = 64'd2147483563;
  localparam longint M2     = 64'd2147483399;
  localparam longint A1     = 64'd40014;
  localparam longint A2     = 64'd40692;
  localparam longint SLOT_W = 1 + (M1 - 1) / SHUF_N;
  localparam int     N_RANDOM  = 600;
  localparam int     LONG_HOLD = 300;

  typedef struct packed {
    logic        cmd;
    logic [30:0] seed;
  } prng_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [30:0] seed, [31] zero
  logic        s_tuser = 1'b0; // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [30:0] deviate, [31] zero

  // predicted generator state
  logic [30:0] g1 = '0;
  logic [30:0] g2 = 31'd123456789;
  logic [30:0] prev_dev = '0;
  logic [30:0] shuffle [SHUF_N] = '{default: '0};

  prng_req_t   pending_q[$];
  logic [30:0] deviate_q[$];
  int n_items;
  int n_accepted = 0;
  int n_errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int results_seen = 0;
  bit long_hold_done = 1'b0;

  combined_lcg_shuffled_prng_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [30:0] mulmod(input logic [30:0] x, input longint a,
                                         input longint m);
    longint p;
    p = longint'(x) * a;
    return 31'(p % m);
  endfunction

  task automatic load_seed(input logic [30:0] s);
    logic [30:0] v;
    v = (s == '0) ? 31'd1 : s;
    g2 = v;
    for (int j = SHUF_N + 7; j >= 0; j--) begin
      v = mulmod(v, A1, M1);
      if (j < SHUF_N) shuffle[j] = v;
    end
    g1 = v;
    prev_dev = shuffle[0];
  endtask

  task automatic advance_draw(output logic [30:0] dev);
    longint slot;
    longint picked;
    longint two;
    g1 = mulmod(g1, A1, M1);
    g2 = mulmod(g2, A2, M2);
    slot = longint'(prev_dev) / SLOT_W;
    if (slot >= SHUF_N) slot = SHUF_N - 1;
    picked = longint'(shuffle[slot]);
    two = longint'(g2);
    if (picked > two) dev = 31'(picked - two);
    else dev = 31'((M1 - 1) - (two - picked));
    shuffle[slot] = g1;
    prev_dev = dev;
  endtask

  task automatic take_item(input prng_req_t req);
    logic [30:0] dev;
    if (req.cmd == clsp_pkg::CMD_RESEED) begin
      load_seed(req.seed);
    end else begin
      advance_draw(dev);
      deviate_q.push_back(dev);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // seeds biased toward zero and the two moduli
  function automatic logic [30:0] pick_seed();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 31'($urandom_range(0, 3));
      1: return 31'(M1 - 2 + $urandom_range(0, 4));
      2: return 31'(M2 - 2 + $urandom_range(0, 4));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic add_req(input logic cmd, input logic [30:0] seed);
    pending_q.push_back('{cmd: cmd, seed: seed});
  endtask

  // driver: hold an item until accepted, then wait out the chosen gap
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_item(pending_q.pop_front());
        n_accepted++;
        send_gap = (n_accepted % 100 < 30) ? 0 : pick_gap();
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap == 0 && pending_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, pending_q[0].seed};
          s_tuser <= pending_q[0].cmd;
        end else begin
          s_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // receiver backpressure, with one long hold to fill the block
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) results_seen++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = (results_seen % 100 < 30) ? 0 : pick_gap();
      end
    end
  end

  // monitor: compare each deviate with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (deviate_q.size() == 0) begin
        $display("%0t: deviate %0d arrived, expected none", $time, m_tdata[30:0]);
        n_errors++;
      end else begin
        logic [30:0] exp_dev;
        exp_dev = deviate_q.pop_front();
        if (m_tdata[30:0] !== exp_dev) begin
          $display("%0t: deviate mismatch, expected %0d, got %0d",
                   $time, exp_dev, m_tdata[30:0]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    // draws straight out of reset: generator one at 0, table empty
    add_req(clsp_pkg::CMD_DRAW, '0);
    add_req(clsp_pkg::CMD_DRAW, '1);
    add_req(clsp_pkg::CMD_DRAW, '0);
    // zero seed acts as one
    add_req(clsp_pkg::CMD_RESEED, '0);
    repeat (3) add_req(clsp_pkg::CMD_DRAW, 31'($urandom));
    add_req(clsp_pkg::CMD_RESEED, '1);
    repeat (2) add_req(clsp_pkg::CMD_DRAW, '1);
    // seed equal to each modulus pins that generator at zero
    add_req(clsp_pkg::CMD_RESEED, 31'(M1));
    repeat (2) add_req(clsp_pkg::CMD_DRAW, '0);
    add_req(clsp_pkg::CMD_RESEED, 31'(M2));
    repeat (2) add_req(clsp_pkg::CMD_DRAW, 31'($urandom));
    add_req(clsp_pkg::CMD_RESEED, 31'(M1 + 1));
    add_req(clsp_pkg::CMD_DRAW, '0);
    add_req(clsp_pkg::CMD_RESEED, 31'd1);
    add_req(clsp_pkg::CMD_RESEED, 31'd12345);
    add_req(clsp_pkg::CMD_DRAW, '1);
    add_req(clsp_pkg::CMD_DRAW, '0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 99) < 7) add_req(clsp_pkg::CMD_RESEED, pick_seed());
      else add_req(clsp_pkg::CMD_DRAW, 31'($urandom));
    end
    n_items = pending_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (n_accepted < n_items || deviate_q.size() != 0);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_combined_lcg_shuffled_prng_top passed");
    end else begin
      $display("tb_combined_lcg_shuffled_prng_top failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("tb_combined_lcg_shuffled_prng_top failed");
    $finish;
  end

endmodule
